// ===== hw/rtl/swa_pkg.sv =====
`timescale 1ns / 1ps

package swa_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WLEN_W   = 7;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [WLEN_W-1:0]          wlen_t;

endpackage

// ===== hw/rtl/swa_sample_if.sv =====
`timescale 1ns / 1ps

interface swa_sample_if;

    logic              valid;
    logic              ready;
    swa_pkg::sample_t  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ===== hw/rtl/swa_result_if.sv =====
`timescale 1ns / 1ps

interface swa_result_if;

    logic              valid;
    logic              ready;
    swa_pkg::sample_t  average;
    logic              window_full;

    modport source (output valid, output average, output window_full, input ready);
    modport sink   (input valid, input average, input window_full, output ready);

endinterface

// ===== hw/rtl/swa_ram.sv =====
`timescale 1ns / 1ps

module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/swa_div.sv =====
`timescale 1ns / 1ps

module swa_div #(
    parameter int DIVIDEND_W = 22,
    parameter int DIVISOR_W  = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  done
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    trial_diff;
    logic [DIVISOR_W-1:0]  rem_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits       = (trial >= {1'b0, divisor_reg});
        trial_diff = trial - {1'b0, divisor_reg};
        rem_next   = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(DIVIDEND_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/sliding_window_average.sv =====
`timescale 1ns / 1ps

// Moving average over the most recent window_length signed Q8.8 samples.
// Samples arrive on the samples channel; each accepted request yields one
// request on the averages channel carrying the running sum divided by the
// number of samples held (truncated toward zero) and a flag that is set once
// the window has filled. During warm-up the average is over fewer samples.
// From acceptance, each sample passes the update, load, divide and finish
// states on its way to the result register. The divide is done by the
// restoring divider, which retires one quotient bit per cycle.
// samples.ready is high only while no sample is in flight, so the block
// takes no new sample before it is through with the last one.
// A result waits in its output register until averages.ready; a new sample
// may be accepted meanwhile, but its result is held back until the register
// is free. Reset clears the window, count, pointer and sum and sets
// window_length to 8. A write of window_length clears the same state; the
// user must write it only while idle, as the block does not enforce this.
// The sample ring has no reset; an entry is used only after it is written.
module sliding_window_average #(
    parameter int RING_DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [swa_pkg::WLEN_W-1:0]   cfg_wr_data,
    swa_sample_if.sink                   samples,
    swa_result_if.source                 averages
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = swa_pkg::SAMPLE_W + $clog2(RING_DEPTH);
    localparam int CMP_W = (CNT_W > swa_pkg::WLEN_W) ? CNT_W : swa_pkg::WLEN_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;

    swa_pkg::wlen_t          wlen_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    full_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    neg_reg;

    logic [PTR_W-1:0]        ptr_cur_reg;
    swa_pkg::sample_t        sample_reg;

    logic                    out_valid_reg;
    swa_pkg::sample_t        out_average_reg;
    logic                    out_full_reg;

    logic [CMP_W-1:0]        wl_ext;
    logic [CMP_W-1:0]        len_wide;
    logic [CNT_W-1:0]        len;
    logic [PTR_W-1:0]        ptr_eff;
    logic [CNT_W-1:0]        ptr_inc;
    logic [PTR_W-1:0]        ptr_next;
    logic [CNT_W-1:0]        cnt_inc;
    logic signed [SUM_W-1:0] old_ext;
    logic signed [SUM_W-1:0] new_ext;
    logic signed [SUM_W-1:0] sum_upd;
    logic [SUM_W-1:0]        sum_mag;
    logic signed [SUM_W-1:0] sum_neg;

    logic                    accept;
    logic                    out_free;
    logic [swa_pkg::SAMPLE_W-1:0] ram_rd_data;

    logic                    div_start;
    logic                    div_done;
    logic [SUM_W-1:0]        div_quotient;
    logic [SUM_W-1:0]        quo_signed;

    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || averages.ready;

    // Window length in effect: zero acts as one, and it never exceeds the ring.
    always_comb
    begin
        wl_ext = CMP_W'(wlen_reg);
        if (wl_ext == '0)
        begin
            len_wide = CMP_W'(1);
        end
        else if (wl_ext > CMP_W'(RING_DEPTH))
        begin
            len_wide = CMP_W'(RING_DEPTH);
        end
        else
        begin
            len_wide = wl_ext;
        end
        len = len_wide[CNT_W-1:0];
    end

    always_comb
    begin
        ptr_eff  = (CNT_W'(ptr_reg) >= len) ? '0 : ptr_reg;
        ptr_inc  = CNT_W'(ptr_cur_reg) + CNT_W'(1);
        ptr_next = (ptr_inc >= len) ? '0 : ptr_inc[PTR_W-1:0];
        cnt_inc  = cnt_reg + CNT_W'(1);
        old_ext  = SUM_W'($signed(ram_rd_data));
        new_ext  = SUM_W'(sample_reg);
        sum_upd  = (full_reg ? (sum_reg - old_ext) : sum_reg) + new_ext;
        sum_neg  = -sum_reg;
        sum_mag  = sum_reg[SUM_W-1] ? $unsigned(sum_neg) : $unsigned(sum_reg);
        quo_signed = neg_reg ? (SUM_W'(0) - div_quotient) : div_quotient;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_start = (state_reg == ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wlen_reg      <= swa_pkg::WLEN_RESET;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                wlen_reg <= cfg_wr_data;
                ptr_reg  <= '0;
                cnt_reg  <= '0;
                full_reg <= 1'b0;
                sum_reg  <= '0;
            end
            else if (state_reg == ST_UPD)
            begin
                ptr_reg <= ptr_next;
                sum_reg <= sum_upd;
                if (!full_reg)
                begin
                    if (cnt_inc >= len)
                    begin
                        cnt_reg  <= len;
                        full_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_inc;
                    end
                end
            end
            if ((state_reg == ST_FIN) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (averages.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= samples.sample;
            ptr_cur_reg <= ptr_eff;
        end
        if (div_start)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            out_average_reg <= $signed(quo_signed[swa_pkg::SAMPLE_W-1:0]);
            out_full_reg    <= full_reg;
        end
    end

    // The oldest sample is fetched at acceptance and arrives in the update cycle.
    swa_ram #(
        .WIDTH (swa_pkg::SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_swa_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_UPD),
        .wr_addr (ptr_cur_reg),
        .wr_data (sample_reg),
        .rd_en   (accept),
        .rd_addr (ptr_eff),
        .rd_data (ram_rd_data)
    );

    swa_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_swa_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (cnt_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );

    assign samples.ready        = (state_reg == ST_IDLE);
    assign averages.valid       = out_valid_reg;
    assign averages.average     = out_average_reg;
    assign averages.window_full = out_full_reg;

endmodule

// ===== hw/rtl/swa_checker.sv =====
`timescale 1ns / 1ps

module swa_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input swa_pkg::sample_t out_average,
    input logic             out_full
);

    // Only one sample is in flight at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted sample");

    // A result is published as the block returns to idle.
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while a sample was still in flight");

    // The divide lies between acceptance and the result, so no result follows an input directly.
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared the cycle after acceptance");

    a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("stalled result request dropped");

    a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_average) && $stable(out_full)))
        else $error("stalled result payload changed");

endmodule

bind sliding_window_average swa_checker u_swa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (samples.valid),
    .in_ready    (samples.ready),
    .out_valid   (averages.valid),
    .out_ready   (averages.ready),
    .out_average (averages.average),
    .out_full    (averages.window_full)
);

// ===== bench/sliding_window_average_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_average_tb;

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int PHASES      = 9;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_SET_WLEN
    } row_kind_e;

    typedef struct {
        row_kind_e        kind;
        logic [15:0]      value;
        bit               known;
        swa_pkg::sample_t average;
        logic             full;
    } stim_row_t;

    typedef struct {
        swa_pkg::sample_t average;
        logic             full;
    } average_t;

    // Directed rows: extremes, warm-up, truncation toward zero, window 0 and
    // a window longer than the ring. Rows with known set carry their result.
    localparam int DIRECTED_ROWS = 29;
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ROW_SAMPLE,   16'h7FFF, 1'b1, 16'sh7FFF,     1'b0},
        '{ROW_SAMPLE,   16'h8000, 1'b1, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'h0000, 1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'h1234, 1'b0, 16'sd0,        1'b0},
        '{ROW_SET_WLEN, 16'd3,    1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'd100,  1'b1, 16'sd100,      1'b0},
        '{ROW_SAMPLE,   16'd200,  1'b1, 16'sd150,      1'b0},
        '{ROW_SAMPLE,   16'd300,  1'b1, 16'sd200,      1'b1},
        '{ROW_SAMPLE,   16'd400,  1'b1, 16'sd300,      1'b1},
        '{ROW_SET_WLEN, 16'd1,    1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'h8000, 1'b1, 16'sh8000,     1'b1},
        '{ROW_SAMPLE,   16'h7FFF, 1'b1, 16'sh7FFF,     1'b1},
        '{ROW_SET_WLEN, 16'd0,    1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'd12345, 1'b1, 16'sd12345,   1'b1},
        '{ROW_SAMPLE,   16'hFFF9, 1'b1, -16'sd7,       1'b1},
        '{ROW_SET_WLEN, 16'd2,    1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'hFFFD, 1'b1, -16'sd3,       1'b0},
        '{ROW_SAMPLE,   16'h0000, 1'b1, -16'sd1,       1'b1},
        '{ROW_SAMPLE,   16'h8000, 1'b1, -16'sd16384,   1'b1},
        '{ROW_SAMPLE,   16'h8000, 1'b1, 16'sh8000,     1'b1},
        '{ROW_SET_WLEN, 16'd127,  1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'h7FFF, 1'b1, 16'sh7FFF,     1'b0},
        '{ROW_SAMPLE,   16'h7FFF, 1'b1, 16'sh7FFF,     1'b0},
        '{ROW_SAMPLE,   16'h7FFF, 1'b1, 16'sh7FFF,     1'b0},
        '{ROW_SAMPLE,   16'h7FFF, 1'b1, 16'sh7FFF,     1'b0},
        '{ROW_SET_WLEN, 16'd65,   1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'h8001, 1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'h5555, 1'b0, 16'sd0,        1'b0},
        '{ROW_SAMPLE,   16'hAAAA, 1'b0, 16'sd0,        1'b0}
    };

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_wr_en;
    swa_pkg::wlen_t cfg_wr_data;

    swa_sample_if samples_ch ();
    swa_result_if averages_ch ();

    sliding_window_average u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .samples     (samples_ch),
        .averages    (averages_ch)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    // Window model: mirrors the ring, the sum, the fill count and the pointer.
    swa_pkg::sample_t held_samples [RING_DEPTH];
    int               next_slot;
    int               held_count;
    logic             window_filled;
    longint           window_sum;
    swa_pkg::wlen_t   wlen_setting;

    average_t pending_averages [$];

    int error_count      = 0;
    int samples_sent     = 0;
    int averages_checked = 0;
    int settings_written = 0;
    int cycle_count      = 0;
    int gap_pct          = 0;
    int stall_pct        = 0;

    function automatic void clear_window_model();
        next_slot     = 0;
        held_count    = 0;
        window_filled = 1'b0;
        window_sum    = 0;
    endfunction

    function automatic average_t advance_window(input swa_pkg::sample_t s);
        average_t r;
        int       span;
        longint   q;
        span = (wlen_setting == '0) ? 1 : ((wlen_setting > RING_DEPTH) ? RING_DEPTH
                                                                        : int'(wlen_setting));
        if (next_slot >= span)
        begin
            next_slot = 0;
        end
        if (!window_filled)
        begin
            held_count++;
            if (held_count >= span)
            begin
                held_count    = span;
                window_filled = 1'b1;
            end
        end
        else
        begin
            window_sum -= held_samples[next_slot];
        end
        held_samples[next_slot] = s;
        window_sum += s;
        next_slot = (next_slot + 1 >= span) ? 0 : next_slot + 1;
        q = window_sum / held_count;
        r.average = q[15:0];
        r.full    = window_filled;
        return r;
    endfunction

    function automatic swa_pkg::sample_t pick_sample(input int bias);
        int v;
        case (bias)
            1: v = 32767 - int'($urandom_range(0, 31));
            2: v = -32768 + int'($urandom_range(0, 31));
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = int'($urandom_range(0, 512)) - 256;
                    default: v = int'($urandom() & 32'hFFFF);
                endcase
            end
        endcase
        return swa_pkg::sample_t'(v);
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
    endtask

    task automatic wait_drained();
        while (pending_averages.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Valid is left high after a request is taken, so the next call either
    // replaces it in the same step or lowers it for a gap.
    task automatic send_sample(input swa_pkg::sample_t s, input bit known,
                               input average_t typed_result);
        average_t predicted;
        int       gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 16);
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        do
        begin
            @(posedge clk);
        end
        while (!samples_ch.ready);
        predicted = advance_window(s);
        pending_averages.push_back(known ? typed_result : predicted);
        samples_sent++;
    endtask

    task automatic write_wlen(input swa_pkg::wlen_t v);
        samples_ch.valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        wlen_setting = v;
        clear_window_model();
        settings_written++;
    endtask

    // Result side: back-pressure in bursts, then compare each taken request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        averages_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                averages_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                averages_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        average_t want;
        if (rst_n && averages_ch.valid && averages_ch.ready)
        begin
            if (pending_averages.size() == 0)
            begin
                flag_error($sformatf("unexpected average %0d full %0b",
                                     averages_ch.average, averages_ch.window_full));
            end
            else
            begin
                want = pending_averages.pop_front();
                averages_checked++;
                if (averages_ch.average !== want.average || averages_ch.window_full !== want.full)
                begin
                    flag_error($sformatf("expected average %0d full %0b, got %0d full %0b",
                                         want.average, want.full,
                                         averages_ch.average, averages_ch.window_full));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d averages outstanding",
                     cycle_count, pending_averages.size());
            $display("sliding_window_average_tb: errors");
            $finish;
        end
    end

    initial
    begin
        average_t       typed_result;
        swa_pkg::wlen_t phase_wlen;
        int             phase_items;
        int             bias;
        int             pct_choice [4];
        pct_choice = '{0, 5, 15, 40};

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        samples_ch.valid   <= 1'b0;
        samples_ch.sample  <= '0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            held_samples[i] = '0;
        end
        wlen_setting = swa_pkg::WLEN_RESET;
        clear_window_model();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 15;
        stall_pct = 15;
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_SET_WLEN)
            begin
                write_wlen(directed_rows[i].value[swa_pkg::WLEN_W-1:0]);
            end
            else
            begin
                typed_result.average = directed_rows[i].average;
                typed_result.full    = directed_rows[i].full;
                send_sample(directed_rows[i].value, directed_rows[i].known, typed_result);
            end
        end

        // Random phases: the ring depth, values above it, 0 and 1, then random lengths.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       phase_wlen = 7'd64;
                1:       phase_wlen = 7'd127;
                2:       phase_wlen = 7'd1;
                3:       phase_wlen = 7'd0;
                4:       phase_wlen = 7'd96;
                5:       phase_wlen = swa_pkg::wlen_t'($urandom_range(0, 127));
                default: phase_wlen = swa_pkg::wlen_t'($urandom_range(2, 63));
            endcase
            write_wlen(phase_wlen);
            phase_items = (phase_wlen >= RING_DEPTH) ? 72 : int'($urandom_range(20, 32));
            bias        = p % 3;
            if (p == PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = pct_choice[$urandom_range(0, 3)];
                stall_pct = pct_choice[$urandom_range(0, 3)];
            end
            for (int i = 0; i < phase_items; i++)
            begin
                // Once, hold the samples back until every average is home.
                if (p == 2 && i == phase_items / 2)
                begin
                    samples_ch.valid <= 1'b0;
                    wait_drained();
                end
                send_sample(pick_sample(bias), 1'b0, typed_result);
            end
        end

        samples_ch.valid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge clk);
        if (pending_averages.size() != 0)
        begin
            flag_error($sformatf("%0d averages never arrived", pending_averages.size()));
        end

        $display("Covered %0d samples over %0d window settings, %0d averages compared.",
                 samples_sent, settings_written, averages_checked);
        $display("Mismatches and stray results: %0d.", error_count);
        if (error_count == 0)
        begin
            $display("sliding_window_average_tb: clean");
        end
        else
        begin
            $display("sliding_window_average_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sliding_window_average.f =====
hw/rtl/swa_pkg.sv
hw/rtl/swa_sample_if.sv
hw/rtl/swa_result_if.sv
hw/rtl/swa_ram.sv
hw/rtl/swa_div.sv
hw/rtl/sliding_window_average.sv
hw/rtl/swa_checker.sv
bench/sliding_window_average_tb.sv
